// ===== src/lkvc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants for the keyed vector cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int MAX_DIM     = 64;
  localparam int WORD_BITS   = 32;
  localparam int KEY_BITS    = 32;
  localparam int SLOT_W      = 4;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;
  localparam int OCC_W       = 5;
  localparam int CFG_W       = 7;

  localparam logic CFG_CAPACITY  = 1'b0;
  localparam logic CFG_EMBED_DIM = 1'b1;

  typedef enum logic [1:0] {
    CMD_STORE    = 2'd0,
    CMD_LOOKUP   = 2'd1,
    CMD_CONTAINS = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_FIND,
    S_DISPATCH,
    S_ALLOC,
    S_COPY,
    S_COPY_END,
    S_RD,
    S_LD,
    S_OUT
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic stage_wr;
    logic find;
    logic touch;
    logic evict;
    logic alloc;
    logic clear;
    logic cnt_clr;
    logic cnt_inc;
    logic vec_rd;
    logic copy_rd;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic stage_done;
    logic found;
    logic need_evict;
    logic cnt_last;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== src/lkvc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_ctrl
// Sequencer for store, lookup, contains and clear transactions.
// ----------------------------------------------------------------------------
module lkvc_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  lkvc_pkg::dp_stat_t stat,
  output lkvc_pkg::dp_cmd_t  cmd
);

  lkvc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lkvc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      lkvc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = lkvc_pkg::S_EXEC;
        end
      end
      lkvc_pkg::S_EXEC: begin
        case (stat.cmd)
          lkvc_pkg::CMD_STORE: begin
            cmd.stage_wr = 1'b1;
            state_next   = stat.stage_done ? lkvc_pkg::S_FIND : lkvc_pkg::S_IDLE;
          end
          lkvc_pkg::CMD_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = lkvc_pkg::S_OUT;
          end
          default: state_next = lkvc_pkg::S_FIND;
        endcase
      end
      lkvc_pkg::S_FIND: begin
        cmd.find   = 1'b1;
        state_next = lkvc_pkg::S_DISPATCH;
      end
      lkvc_pkg::S_DISPATCH: begin
        case (stat.cmd)
          lkvc_pkg::CMD_STORE: begin
            if (stat.found) begin
              cmd.touch   = 1'b1;
              cmd.cnt_clr = 1'b1;
              state_next  = lkvc_pkg::S_COPY;
            end else begin
              cmd.evict  = stat.need_evict;
              state_next = lkvc_pkg::S_ALLOC;
            end
          end
          lkvc_pkg::CMD_LOOKUP: begin
            if (stat.found) begin
              cmd.touch   = 1'b1;
              cmd.cnt_clr = 1'b1;
              state_next  = lkvc_pkg::S_RD;
            end else begin
              state_next = lkvc_pkg::S_OUT;
            end
          end
          default: state_next = lkvc_pkg::S_OUT;
        endcase
      end
      lkvc_pkg::S_ALLOC: begin
        cmd.alloc   = 1'b1;
        cmd.cnt_clr = 1'b1;
        state_next  = lkvc_pkg::S_COPY;
      end
      lkvc_pkg::S_COPY: begin
        cmd.copy_rd = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (stat.cnt_last) state_next = lkvc_pkg::S_COPY_END;
      end
      lkvc_pkg::S_COPY_END: begin
        // last staged word lands in the vector memory this cycle
        state_next = lkvc_pkg::S_OUT;
      end
      lkvc_pkg::S_RD: begin
        cmd.vec_rd = 1'b1;
        state_next = lkvc_pkg::S_LD;
      end
      lkvc_pkg::S_LD: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (stat.cnt_last) begin
            state_next = lkvc_pkg::S_IDLE;
          end else begin
            cmd.cnt_inc = 1'b1;
            state_next  = lkvc_pkg::S_RD;
          end
        end
      end
      lkvc_pkg::S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = lkvc_pkg::S_IDLE;
        end
      end
      default: state_next = lkvc_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/lkvc_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_dpath
// Entry tags, age ranks, staging buffer, vector memory and output register.
// ----------------------------------------------------------------------------
module lkvc_dpath (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_we,
  input  wire                                cfg_index,
  input  wire  [lkvc_pkg::CFG_W-1:0]         cfg_data,
  input  wire  [1:0]                         in_cmd,
  input  wire  [lkvc_pkg::KEY_BITS-1:0]      in_key,
  input  wire  [lkvc_pkg::WORD_BITS-1:0]     in_word,
  input  lkvc_pkg::dp_cmd_t                  cmd,
  output lkvc_pkg::dp_stat_t                 stat,
  input  wire                                out_ready,
  output logic                               out_valid,
  output logic                               out_hit,
  output logic [lkvc_pkg::WORD_BITS-1:0]     out_word,
  output logic                               out_last,
  output logic                               out_evicted,
  output logic [lkvc_pkg::KEY_BITS-1:0]      out_evicted_key,
  output logic [lkvc_pkg::OCC_W-1:0]         out_occupancy
);

  // configuration
  logic [4:0] capacity;
  logic [6:0] embed_dim;
  logic [4:0] eff_cap;
  logic [6:0] eff_dim;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= 5'd16;
      embed_dim <= 7'd16;
    end else if (cfg_we) begin
      if (cfg_index == lkvc_pkg::CFG_CAPACITY) capacity <= cfg_data[4:0];
      else                                     embed_dim <= cfg_data;
    end
  end

  always_comb begin
    eff_cap = capacity;
    if (capacity == 5'd0) eff_cap = 5'd1;
    else if (capacity > lkvc_pkg::OCC_W'(lkvc_pkg::MAX_ENTRIES))
      eff_cap = lkvc_pkg::OCC_W'(lkvc_pkg::MAX_ENTRIES);
    eff_dim = embed_dim;
    if (embed_dim == 7'd0) eff_dim = 7'd1;
    else if (embed_dim > lkvc_pkg::CNT_W'(lkvc_pkg::MAX_DIM))
      eff_dim = lkvc_pkg::CNT_W'(lkvc_pkg::MAX_DIM);
  end

  // input transaction
  lkvc_pkg::cmd_t                 cmd_r;
  logic [lkvc_pkg::KEY_BITS-1:0]  key_r;
  logic [lkvc_pkg::WORD_BITS-1:0] word_r;

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cmd_r  <= lkvc_pkg::cmd_t'(in_cmd);
      key_r  <= in_key;
      word_r <= in_word;
    end
  end

  // staging buffer
  logic [lkvc_pkg::WORD_BITS-1:0] staging [lkvc_pkg::MAX_DIM];
  logic [lkvc_pkg::CNT_W-1:0]     staging_count;
  logic [lkvc_pkg::CNT_W-1:0]     staging_count_next;
  logic [lkvc_pkg::KEY_BITS-1:0]  staging_key;
  logic [lkvc_pkg::WORD_BITS-1:0] stage_rdata;
  logic [lkvc_pkg::IDX_W-1:0]     cnt;

  assign staging_count_next = (staging_count < lkvc_pkg::CNT_W'(lkvc_pkg::MAX_DIM)) ?
                              staging_count + 7'd1 : staging_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      staging_count <= '0;
      staging_key   <= '0;
    end else if (cmd.clear) begin
      staging_count <= '0;
    end else if (cmd.stage_wr) begin
      if (staging_count == 7'd0) staging_key <= key_r;
      staging_count <= (staging_count_next >= eff_dim) ? 7'd0 : staging_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.stage_wr && staging_count < lkvc_pkg::CNT_W'(lkvc_pkg::MAX_DIM))
      staging[staging_count[lkvc_pkg::IDX_W-1:0]] <= word_r;
    if (cmd.copy_rd)
      stage_rdata <= staging[cnt];
  end

  // entry tags and ranks
  logic [lkvc_pkg::MAX_ENTRIES-1:0] valid;
  logic [lkvc_pkg::KEY_BITS-1:0] keys  [lkvc_pkg::MAX_ENTRIES];
  logic [lkvc_pkg::SLOT_W-1:0]   rank  [lkvc_pkg::MAX_ENTRIES];
  logic [lkvc_pkg::OCC_W-1:0]    occ;
  logic [lkvc_pkg::SLOT_W-1:0]   slot;
  logic                          found;
  logic                          ev;
  logic [lkvc_pkg::KEY_BITS-1:0] ev_key;

  logic [lkvc_pkg::KEY_BITS-1:0] find_key;
  logic                          hit_any;
  logic [lkvc_pkg::SLOT_W-1:0]   hit_slot;
  logic [lkvc_pkg::SLOT_W-1:0]   old_slot;
  logic [lkvc_pkg::SLOT_W-1:0]   free_slot;
  logic [lkvc_pkg::OCC_W-1:0]    occ_m1;
  logic [lkvc_pkg::SLOT_W-1:0]   slot_rank;

  assign find_key  = (cmd_r == lkvc_pkg::CMD_STORE) ? staging_key : key_r;
  assign occ_m1    = occ - 5'd1;
  assign slot_rank = rank[slot];

  always_comb begin
    hit_any   = 1'b0;
    hit_slot  = '0;
    old_slot  = '0;
    free_slot = '0;
    for (int i = lkvc_pkg::MAX_ENTRIES - 1; i >= 0; i--) begin
      if (valid[i] && keys[i] == find_key) begin
        hit_any  = 1'b1;
        hit_slot = lkvc_pkg::SLOT_W'(i);
      end
      // ranks of valid entries are a permutation of 0..occ-1
      if (valid[i] && {1'b0, rank[i]} == occ_m1) old_slot = lkvc_pkg::SLOT_W'(i);
      if (!valid[i]) free_slot = lkvc_pkg::SLOT_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      occ   <= '0;
    end else if (cmd.clear) begin
      valid <= '0;
      occ   <= '0;
    end else if (cmd.evict) begin
      valid[old_slot] <= 1'b0;
      occ             <= occ - 5'd1;
    end else if (cmd.alloc) begin
      valid[free_slot] <= 1'b1;
      occ              <= occ + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.find) begin
      found <= hit_any;
      slot  <= hit_slot;
      ev    <= 1'b0;
    end
    if (cmd.evict) begin
      ev     <= 1'b1;
      ev_key <= keys[old_slot];
    end
    if (cmd.alloc) begin
      slot            <= free_slot;
      keys[free_slot] <= staging_key;
    end
    for (int i = 0; i < lkvc_pkg::MAX_ENTRIES; i++) begin
      if (cmd.touch && valid[i]) begin
        if (lkvc_pkg::SLOT_W'(i) == slot) rank[i] <= '0;
        else if (rank[i] < slot_rank)     rank[i] <= rank[i] + 4'd1;
      end
      if (cmd.alloc) begin
        if (lkvc_pkg::SLOT_W'(i) == free_slot) rank[i] <= '0;
        else if (valid[i])                     rank[i] <= rank[i] + 4'd1;
      end
    end
  end

  // word counter shared by copy and readout
  logic                       cnt_last;
  assign cnt_last = ({1'b0, cnt} == eff_dim - 7'd1);

  always_ff @(posedge clk) begin
    if (cmd.cnt_clr)      cnt <= '0;
    else if (cmd.cnt_inc) cnt <= cnt + 6'd1;
  end

  // vector memory
  logic [lkvc_pkg::WORD_BITS-1:0] vmem [lkvc_pkg::MAX_ENTRIES * lkvc_pkg::MAX_DIM];
  logic [lkvc_pkg::WORD_BITS-1:0] vec_rdata;
  logic                           copy_pend;
  logic [lkvc_pkg::IDX_W-1:0]     copy_idx;

  always_ff @(posedge clk) begin
    if (rst) copy_pend <= 1'b0;
    else     copy_pend <= cmd.copy_rd;
  end

  always_ff @(posedge clk) begin
    if (cmd.copy_rd) copy_idx <= cnt;
    if (copy_pend)   vmem[{slot, copy_idx}] <= stage_rdata;
    if (cmd.vec_rd)  vec_rdata <= vmem[{slot, cnt}];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_hit         <= 1'b0;
      out_word        <= '0;
      out_last        <= 1'b1;
      out_evicted     <= 1'b0;
      out_evicted_key <= '0;
      out_occupancy   <= occ;
      case (cmd_r)
        lkvc_pkg::CMD_STORE: begin
          out_hit         <= found;
          out_evicted     <= ev;
          out_evicted_key <= ev ? ev_key : '0;
        end
        lkvc_pkg::CMD_LOOKUP: begin
          if (found) begin
            out_hit  <= 1'b1;
            out_word <= vec_rdata;
            out_last <= cnt_last;
          end
        end
        lkvc_pkg::CMD_CONTAINS: out_hit <= found;
        default: out_occupancy <= '0;
      endcase
    end
  end

  assign stat.cmd        = cmd_r;
  assign stat.stage_done = (staging_count_next >= eff_dim);
  assign stat.found      = found;
  assign stat.need_evict = (occ >= eff_cap);
  assign stat.cnt_last   = cnt_last;
  assign stat.out_free   = !out_valid || out_ready;

endmodule
`default_nettype wire

// ===== src/lru_keyed_vector_cache.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_keyed_vector_cache
// Fully associative LRU cache of keyed vectors with a streaming interface.
// ----------------------------------------------------------------------------
// Store element: each element is staged; the final element then searches, allocates (unless
//   the key exists) and copies the vector into the vector memory one word per cycle.
// Lookup hit: each word is a vector memory read then an output register load. A result
//   load for any command waits while the output register is full and the sink stalls.
// Reset (rst, synchronous): cache empty, staging empty, capacity 16, dim 16.
module lru_keyed_vector_cache (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire         cfg_index,
  input  wire  [6:0]  cfg_data,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [63:0] s_axis_tdata,   // token_key, element_word
  input  wire  [1:0]  s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [71:0] m_axis_tdata,   // out_word, evicted_key, occupancy, zero pad
  output logic        m_axis_tlast,
  output logic [1:0]  m_axis_tuser    // hit, evicted
);

  lkvc_pkg::dp_cmd_t  cmd;
  lkvc_pkg::dp_stat_t stat;

  logic        hit;
  logic [31:0] out_word;
  logic        evicted;
  logic [31:0] evicted_key;
  logic [4:0]  occupancy;

  lkvc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lkvc_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_cmd          (s_axis_tuser),
    .in_key          (s_axis_tdata[31:0]),
    .in_word         (s_axis_tdata[63:32]),
    .cmd             (cmd),
    .stat            (stat),
    .out_ready       (m_axis_tready),
    .out_valid       (m_axis_tvalid),
    .out_hit         (hit),
    .out_word        (out_word),
    .out_last        (m_axis_tlast),
    .out_evicted     (evicted),
    .out_evicted_key (evicted_key),
    .out_occupancy   (occupancy)
  );

  assign m_axis_tdata = {3'b000, occupancy, evicted_key, out_word};
  assign m_axis_tuser = {evicted, hit};

endmodule
`default_nettype wire
